// ----- rtl/hckt_pkg.sv -----
package hckt_pkg;

	localparam int NAME_MAX_LEN = 256;
	localparam int VALUE_MAX_LEN = 4096;
	localparam int HEADER_MAX_BYTES = 16 * 1024;
	localparam int NAME_LEN_W = 9;
	localparam int VALUE_LEN_W = 13;
	localparam int HDR_CNT_W = 15;
	localparam int NUM_KW = 9;
	localparam int KW_CHARS = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	typedef enum logic [1:0] {
		PH_NAME  = 2'd0,
		PH_VALUE = 2'd1,
		PH_SKIP  = 2'd2,
		PH_ERROR = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		QK_NONE   = 2'd0,
		QK_SINGLE = 2'd1,
		QK_DOUBLE = 2'd2
	} quote_t;

	typedef enum logic [2:0] {
		KIND_NAME  = 3'd0,
		KIND_VALUE = 3'd1,
		KIND_PAIR  = 3'd2,
		KIND_ERROR = 3'd3,
		KIND_DONE  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0] count;
		kind_t [2:0] kind;
		logic [7:0] data;
		logic kept;
	} job_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic kept;
		logic last;
	} token_t;

	localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
		'{"c","o","m","m","e","n","t",8'h00},
		'{"d","o","m","a","i","n",8'h00,8'h00},
		'{"m","a","x","-","a","g","e",8'h00},
		'{"p","a","t","h",8'h00,8'h00,8'h00,8'h00},
		'{"s","e","c","u","r","e",8'h00,8'h00},
		'{"v","e","r","s","i","o","n",8'h00},
		'{"e","x","p","i","r","e","s",8'h00},
		'{"h","t","t","p","o","n","l","y"},
		'{"s","a","m","e","s","i","t","e"}
	};
	localparam int KW_LEN [NUM_KW] = '{7, 6, 7, 4, 6, 7, 7, 8, 8};

endpackage

// ----- rtl/hckt_front.sv -----
module hckt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             set_cookie_mode,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             job_valid,
	input  logic             job_ready,
	output hckt_pkg::job_t   job
);

	hckt_pkg::phase_t phase_q;
	hckt_pkg::quote_t quote_q;
	logic [hckt_pkg::NAME_LEN_W-1:0] name_len_q;
	logic [hckt_pkg::VALUE_LEN_W-1:0] value_len_q;
	logic [hckt_pkg::NUM_KW-1:0] kw_q;
	logic dollar_q;
	logic [hckt_pkg::HDR_CNT_W-1:0] hdr_cnt_q;

	logic [7:0] c, lc;
	logic sep, blank, ctl, fire;
	logic [hckt_pkg::NUM_KW-1:0] kw_next, kw_hit;
	logic [hckt_pkg::NUM_KW-1:0] kw_after;
	logic [hckt_pkg::NAME_LEN_W-1:0] nl_after;
	logic keep_now, keep_next;
	hckt_pkg::job_t j;
	logic clr_pair;
	hckt_pkg::phase_t ph_n;
	hckt_pkg::quote_t qk_n;
	logic nm_take, val_take;

	assign in_ready = job_ready;
	assign job_valid = in_valid;
	assign fire = in_valid && in_ready;
	assign c = in_byte;
	assign lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	assign sep = (c == 8'h3B) || (c == 8'h2C);
	assign blank = (c == 8'h20) || (c == 8'h09);
	assign ctl = (c < 8'h20) || (c == 8'h7F);

	always_comb begin
		for (int k = 0; k < hckt_pkg::NUM_KW; k++) begin
			kw_hit[k] = kw_q[k] &&
				(name_len_q == hckt_pkg::NAME_LEN_W'(hckt_pkg::KW_LEN[k]));
			kw_next[k] = kw_q[k] &&
				(name_len_q < hckt_pkg::NAME_LEN_W'(hckt_pkg::KW_LEN[k])) &&
				(lc == hckt_pkg::KW_TEXT[k][name_len_q[2:0]]);
		end
	end

	always_comb begin
		nl_after = name_len_q + hckt_pkg::NAME_LEN_W'(1);
		for (int k = 0; k < hckt_pkg::NUM_KW; k++)
			kw_after[k] = kw_next[k] && (nl_after == hckt_pkg::NAME_LEN_W'(hckt_pkg::KW_LEN[k]));
	end

	assign keep_now = (name_len_q != '0) && !dollar_q && !(set_cookie_mode && |kw_hit);

	always_comb begin
		j = '0;
		ph_n = phase_q;
		qk_n = quote_q;
		clr_pair = 1'b0;
		nm_take = 1'b0;
		val_take = 1'b0;
		keep_next = keep_now;
		if (phase_q != hckt_pkg::PH_ERROR) begin
			if (hdr_cnt_q >= hckt_pkg::HDR_CNT_W'(hckt_pkg::HEADER_MAX_BYTES)) begin
				j.kind[0] = hckt_pkg::KIND_ERROR; j.count = 2'd1;
				ph_n = hckt_pkg::PH_ERROR;
			end else begin
				unique case (phase_q)
					hckt_pkg::PH_NAME: begin
						if (c == 8'h3D) begin
							ph_n = hckt_pkg::PH_VALUE;
							qk_n = hckt_pkg::QK_NONE;
						end else if (sep) begin
							if (name_len_q != '0) begin
								j.kind[0] = hckt_pkg::KIND_PAIR; j.kept = keep_now;
								j.count = 2'd1; clr_pair = 1'b1;
							end
						end else if (!blank) begin
							if (ctl || name_len_q >= hckt_pkg::NAME_LEN_W'(hckt_pkg::NAME_MAX_LEN)) begin
								j.kind[0] = hckt_pkg::KIND_ERROR; j.count = 2'd1;
								ph_n = hckt_pkg::PH_ERROR;
							end else begin
								nm_take = 1'b1;
								j.kind[0] = hckt_pkg::KIND_NAME; j.data = c; j.count = 2'd1;
							end
						end
					end
					hckt_pkg::PH_VALUE: begin
						if (quote_q == hckt_pkg::QK_NONE) begin
							if (sep) begin
								j.kind[0] = hckt_pkg::KIND_PAIR; j.kept = keep_now;
								j.count = 2'd1; clr_pair = 1'b1; ph_n = hckt_pkg::PH_NAME;
							end else if ((c == 8'h27 || c == 8'h22) && value_len_q == '0) begin
								qk_n = (c == 8'h22) ? hckt_pkg::QK_DOUBLE : hckt_pkg::QK_SINGLE;
							end else if (!blank || value_len_q != '0) begin
								if (ctl || value_len_q >= hckt_pkg::VALUE_LEN_W'(hckt_pkg::VALUE_MAX_LEN)) begin
									j.kind[0] = hckt_pkg::KIND_ERROR; j.count = 2'd1;
									ph_n = hckt_pkg::PH_ERROR;
								end else begin
									val_take = 1'b1;
									j.kind[0] = hckt_pkg::KIND_VALUE; j.data = c; j.count = 2'd1;
								end
							end
						end else begin
							if (c == ((quote_q == hckt_pkg::QK_DOUBLE) ? 8'h22 : 8'h27)) begin
								j.kind[0] = hckt_pkg::KIND_PAIR; j.kept = keep_now;
								j.count = 2'd1; clr_pair = 1'b1; ph_n = hckt_pkg::PH_SKIP;
							end else if (value_len_q >= hckt_pkg::VALUE_LEN_W'(hckt_pkg::VALUE_MAX_LEN)) begin
								j.kind[0] = hckt_pkg::KIND_ERROR; j.count = 2'd1;
								ph_n = hckt_pkg::PH_ERROR;
							end else begin
								val_take = 1'b1;
								j.kind[0] = hckt_pkg::KIND_VALUE; j.data = c; j.count = 2'd1;
							end
						end
					end
					default: begin
						if (sep) ph_n = hckt_pkg::PH_NAME;
					end
				endcase
			end
		end
		if (in_last) begin
			if (nm_take)
				keep_next = !(dollar_q || (name_len_q == '0 && c == 8'h24)) &&
					!(set_cookie_mode && |kw_after);
			if (!clr_pair && (ph_n == hckt_pkg::PH_VALUE ||
				(ph_n == hckt_pkg::PH_NAME && (name_len_q != '0 || nm_take)))) begin
				j.kind[j.count] = hckt_pkg::KIND_PAIR;
				j.kept = keep_next;
				j.count = j.count + 2'd1;
			end
			j.kind[j.count] = hckt_pkg::KIND_DONE;
			j.count = j.count + 2'd1;
		end
	end

	assign job = j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hckt_pkg::PH_NAME;
			quote_q <= hckt_pkg::QK_NONE;
			name_len_q <= '0;
			value_len_q <= '0;
			kw_q <= '1;
			dollar_q <= 1'b0;
			hdr_cnt_q <= '0;
		end else if (fire) begin
			if (in_last) begin
				phase_q <= hckt_pkg::PH_NAME;
				quote_q <= hckt_pkg::QK_NONE;
				name_len_q <= '0;
				value_len_q <= '0;
				kw_q <= '1;
				dollar_q <= 1'b0;
				hdr_cnt_q <= '0;
			end else begin
				phase_q <= ph_n;
				if (phase_q != hckt_pkg::PH_ERROR && ph_n != hckt_pkg::PH_ERROR)
					hdr_cnt_q <= hdr_cnt_q + hckt_pkg::HDR_CNT_W'(1);
				if (clr_pair) begin
					quote_q <= hckt_pkg::QK_NONE;
					name_len_q <= '0;
					value_len_q <= '0;
					kw_q <= '1;
					dollar_q <= 1'b0;
				end else begin
					quote_q <= qk_n;
					if (phase_q == hckt_pkg::PH_NAME && c == 8'h3D)
						value_len_q <= '0;
					if (nm_take) begin
						kw_q <= kw_next;
						name_len_q <= nl_after;
						if (name_len_q == '0 && c == 8'h24) dollar_q <= 1'b1;
					end
					if (val_take) value_len_q <= value_len_q + hckt_pkg::VALUE_LEN_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/hckt_queue.sv -----
module hckt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  hckt_pkg::job_t   wr_job,
	output logic             rd_valid,
	input  logic             rd_ready,
	output hckt_pkg::job_t   rd_job
);

	hckt_pkg::job_t mem_q [hckt_pkg::QUEUE_DEPTH];
	logic [hckt_pkg::QUEUE_PTR_W-1:0] wp_q, rp_q;
	logic [hckt_pkg::QUEUE_PTR_W:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (hckt_pkg::QUEUE_PTR_W+1)'(hckt_pkg::QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job = mem_q[rp_q];
	assign wr = wr_valid && wr_ready && (wr_job.count != 2'd0);
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + hckt_pkg::QUEUE_PTR_W'(1);
			if (rd) rp_q <= rp_q + hckt_pkg::QUEUE_PTR_W'(1);
			cnt_q <= cnt_q + {{hckt_pkg::QUEUE_PTR_W{1'b0}}, wr} -
				{{hckt_pkg::QUEUE_PTR_W{1'b0}}, rd};
		end
	end

endmodule

// ----- rtl/hckt_back.sv -----
module hckt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  hckt_pkg::job_t   job,
	output logic             tok_valid,
	input  logic             tok_ready,
	output hckt_pkg::token_t tok
);

	logic [1:0] idx_q;
	logic is_last, adv;
	hckt_pkg::kind_t k;

	assign k = job.kind[idx_q];
	assign is_last = (idx_q + 2'd1) == job.count;
	assign tok_valid = job_valid;
	assign adv = tok_valid && tok_ready;
	assign job_ready = adv && is_last;

	always_comb begin
		tok.kind = k;
		tok.data = (k == hckt_pkg::KIND_NAME || k == hckt_pkg::KIND_VALUE) ? job.data : 8'h00;
		tok.kept = (k == hckt_pkg::KIND_PAIR) ? job.kept : 1'b0;
		tok.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (adv) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
	end

endmodule

// ----- rtl/http_cookie_header_tokenizer.sv -----
// channel | dir | tdata                            | tuser            | tlast
// s_axis  | in  | [7:0] header_byte                | -                | end_of_header
// m_axis  | out | [7:0] token_byte, [8] pair_kept  | [2:0] token_kind | last_of_run
// cfg     | in  | set_cookie_mode via cfg_we/cfg_wdata
// One byte enters per cycle while the job queue has room; its job, if any, is
// written into the queue and its first token leaves from there. A byte yields up
// to three tokens, sent one at a time and absorbed by a four-entry job queue.
// Reset clears the parser state and the queue; the mode register resets to 0.
// Input stalls only when the job queue is full.
module http_cookie_header_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // header_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // token_byte, pair_kept
	output logic [2:0]  m_axis_tuser,   // token_kind
	output logic        m_axis_tlast
);

	logic mode_q;
	logic jv, jr, qv, qr;
	hckt_pkg::job_t jf, jq;
	hckt_pkg::token_t t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	hckt_front u_front (.clk, .arst_n, .set_cookie_mode(mode_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
		.in_last(s_axis_tlast), .job_valid(jv), .job_ready(jr), .job(jf));
	hckt_queue u_queue (.clk, .arst_n, .wr_valid(jv), .wr_ready(jr), .wr_job(jf),
		.rd_valid(qv), .rd_ready(qr), .rd_job(jq));
	hckt_back u_back (.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(jq),
		.tok_valid(m_axis_tvalid), .tok_ready(m_axis_tready), .tok(t));

	assign m_axis_tdata = {7'b0, t.kept, t.data};
	assign m_axis_tuser = t.kind;
	assign m_axis_tlast = t.last;

	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != hckt_pkg::KIND_PAIR |-> !m_axis_tdata[8])
		else $error("kept");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == hckt_pkg::KIND_DONE |-> m_axis_tlast)
		else $error("done");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("hold");

endmodule
